[hdl/epawd_pkg.sv]
// Package for the EMA peak amplitude window detector.
// Holds widths, reset values, register indexes and sequencer states.
// No dependencies.
package epawd_pkg;

  // Sample and fixed-point format
  localparam int ADC_BITS    = 10;
  localparam int FRAC_BITS   = 8;
  localparam int VAL_BITS    = ADC_BITS + FRAC_BITS;
  localparam int ALPHA_SHIFT = 8;

  // Register widths
  localparam int ALPHA_W  = ALPHA_SHIFT + 1;
  localparam int WIN_W    = 10;
  localparam int RDG_W    = 7;
  localparam int THR_W    = ADC_BITS;
  localparam int CFG_W    = 10;
  localparam int CFG_IDX_W = 3;

  // Limits
  localparam int MAX_READINGS   = 64;
  localparam int DEBOUNCE_LIMIT = 3;
  localparam int DEB_W          = 2;

  // Running sums hold up to MAX_READINGS values of VAL_BITS + 1 bits
  localparam int SUM_W   = VAL_BITS + 1 + $clog2(MAX_READINGS);
  localparam int DCNT_W  = $clog2(SUM_W);
  localparam int PROD_W  = VAL_BITS + ALPHA_SHIFT;

  // Stream word widths, padded to whole bytes
  localparam int S_DATA_W = ((ADC_BITS + 7) / 8) * 8;
  localparam int M_DATA_W = ((4 * VAL_BITS + 7) / 8) * 8;

  // Reset values
  localparam logic [ALPHA_W-1:0] ALPHA_RST = ALPHA_W'(26);
  localparam logic [WIN_W-1:0]   WIN_RST   = WIN_W'(20);
  localparam logic [RDG_W-1:0]   RDG_RST   = RDG_W'(10);
  localparam logic [THR_W-1:0]   LOW_RST   = THR_W'(190);
  localparam logic [THR_W-1:0]   HIGH_RST  = THR_W'(240);
  localparam logic [VAL_BITS:0]  MIN_RST   = {1'b1, {VAL_BITS{1'b0}}};
  localparam logic [ALPHA_W-1:0] ALPHA_MAX = ALPHA_W'(1 << ALPHA_SHIFT);
  localparam logic [VAL_BITS-1:0] VAL_MAX  = {VAL_BITS{1'b1}};

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_RDG    = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_LOW    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH   = CFG_IDX_W'(4);

  // Which running sum the divider works on
  typedef enum logic [1:0] {
    SEL_MAX,
    SEL_MID,
    SEL_MIN
  } sel_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WIN,
    ST_DLOAD,
    ST_DIV,
    ST_DSTORE,
    ST_AMP,
    ST_EMIT,
    ST_MUL,
    ST_ADD,
    ST_TRK
  } state_e;

endpackage

[hdl/ema_peak_amplitude_window_detector.sv]
// EMA peak amplitude window detector, top level.
// Smooths samples, tracks window extremes, averages them with a shared divider.
// Depends on epawd_pkg.
//
//  channel   | direction | tdata (low bit up)               | tuser
//  s_axis    | in        | sample                           | tick
//  m_axis    | out       | max_avg, mid_avg, min_avg, ampl. | ready_res
//  cfg       | in        | write enable, index, data        | -
//
// A word that closes no reading keeps the input busy through ST_WIN, ST_MUL, ST_ADD and
// ST_TRK; no new word is taken until then. A word that closes a reading also runs the
// divider, which gives one quotient bit a cycle for each of the three sums, and then
// ST_AMP and ST_EMIT. Reset is asynchronous and active low and loads the register defaults.
// The result sits in an output register; a stalled output holds the sequencer only
// when the next result is ready to be loaded.
module ema_peak_amplitude_window_detector
  import epawd_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // tdata: sample [ADC_BITS-1:0], zero padding above
  input  logic [S_DATA_W-1:0]  s_axis_tdata,
  // tuser: tick
  input  logic                 s_axis_tuser,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // tdata: max_avg, mid_avg, min_avg, amplitude, VAL_BITS each
  output logic [M_DATA_W-1:0]  m_axis_tdata,
  // tuser: ready_res
  output logic                 m_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  state_e state_q, state_d;

  // Configuration
  logic [ALPHA_W-1:0] alpha_q;
  logic [WIN_W-1:0]   win_q;
  logic [RDG_W-1:0]   rdg_q;
  logic [THR_W-1:0]   low_q, high_q;

  // Item and tracking state
  logic [ADC_BITS-1:0] y_q, y_d;
  logic                tick_q, tick_d;
  logic [VAL_BITS-1:0] smooth_q, smooth_d;
  logic [VAL_BITS-1:0] wmax_q, wmax_d;
  logic [VAL_BITS:0]   wmin_q, wmin_d;
  logic [WIN_W-1:0]    tcnt_q, tcnt_d;
  logic [SUM_W-1:0]    smax_q, smax_d, smid_q, smid_d, smin_q, smin_d;
  logic [RDG_W-1:0]    wcnt_q, wcnt_d;
  logic [DEB_W-1:0]    deb_q, deb_d;
  logic [PROD_W-1:0]   prod_q, prod_d;

  // Divider and result
  sel_e                sel_q, sel_d;
  logic [RDG_W-1:0]    rem_q, rem_d;
  logic [SUM_W-1:0]    quo_q, quo_d;
  logic [DCNT_W-1:0]   dcnt_q, dcnt_d;
  logic [VAL_BITS-1:0] amax_q, amax_d, amid_q, amid_d, amin_q, amin_d, amp_q, amp_d;

  // Output register
  logic                ovld_q, ovld_d;
  logic [M_DATA_W-1:0] odata_q, odata_d;
  logic                ouser_q, ouser_d;

  // Effective register values
  logic [ALPHA_W-1:0] alpha_eff;
  logic [WIN_W-1:0]   wlen;
  logic [RDG_W-1:0]   rlen;

  // Working signals
  logic [WIN_W-1:0]      tcnt_inc;
  logic [RDG_W-1:0]      wcnt_inc;
  logic [VAL_BITS+1:0]   mid_sum;
  logic [VAL_BITS:0]     diff;
  logic [VAL_BITS+ALPHA_W:0] prod_full;
  logic [RDG_W:0]        dshift;
  logic                  dge;
  logic [VAL_BITS-1:0]   quo_sat;
  logic [VAL_BITS-1:0]   thr_lo, thr_hi;
  logic                  in_range;
  logic                  out_free;

  assign alpha_eff = (alpha_q > ALPHA_MAX) ? ALPHA_MAX : alpha_q;
  assign wlen      = (win_q == '0) ? WIN_W'(1) : win_q;
  assign rlen      = (rdg_q == '0) ? RDG_W'(1) :
                     (rdg_q > RDG_W'(MAX_READINGS)) ? RDG_W'(MAX_READINGS) : rdg_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;
  assign out_free      = !ovld_q || m_axis_tready;

  assign tcnt_inc  = tcnt_q + WIN_W'(1);
  assign wcnt_inc  = wcnt_q + RDG_W'(1);
  assign mid_sum   = {1'b0, wmax_q} + {1'b0, wmin_q};

  // Shared datapath pieces: signed difference times alpha, one divider step
  assign diff      = {1'b0, y_q, {FRAC_BITS{1'b0}}} - {1'b0, smooth_q};
  assign prod_full = $signed({1'b0, alpha_eff}) * $signed(diff);
  assign dshift    = {rem_q, quo_q[SUM_W-1]};
  assign dge       = dshift >= {1'b0, rlen};
  assign quo_sat   = (quo_q > SUM_W'(VAL_MAX)) ? VAL_MAX : quo_q[VAL_BITS-1:0];

  assign thr_lo    = {low_q, {FRAC_BITS{1'b0}}};
  assign thr_hi    = {high_q, {FRAC_BITS{1'b0}}};
  assign in_range  = (amp_q > thr_lo) && (amp_q < thr_hi);

  // Sequencer: next state and datapath next values
  always_comb begin
    state_d  = state_q;
    y_d      = y_q;
    tick_d   = tick_q;
    smooth_d = smooth_q;
    wmax_d   = wmax_q;
    wmin_d   = wmin_q;
    tcnt_d   = tcnt_q;
    smax_d   = smax_q;
    smid_d   = smid_q;
    smin_d   = smin_q;
    wcnt_d   = wcnt_q;
    deb_d    = deb_q;
    prod_d   = prod_q;
    sel_d    = sel_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    dcnt_d   = dcnt_q;
    amax_d   = amax_q;
    amid_d   = amid_q;
    amin_d   = amin_q;
    amp_d    = amp_q;
    ovld_d   = ovld_q && !m_axis_tready;
    odata_d  = odata_q;
    ouser_d  = ouser_q;

    case (state_q)
      // Take a word
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          y_d     = s_axis_tdata[ADC_BITS-1:0];
          tick_d  = s_axis_tuser;
          state_d = ST_WIN;
        end
      end
      // Advance the tick count; close the window before the sample is used, and start the divider when a reading closes
      ST_WIN: begin
        state_d = ST_MUL;
        if (tick_q) begin
          tcnt_d = tcnt_inc;
          if (tcnt_inc >= wlen) begin
            smax_d = smax_q + SUM_W'(wmax_q);
            smid_d = smid_q + SUM_W'(mid_sum[VAL_BITS+1:1]);
            smin_d = smin_q + SUM_W'(wmin_q);
            wmax_d = '0;
            wmin_d = MIN_RST;
            tcnt_d = '0;
            wcnt_d = wcnt_inc;
            if (wcnt_inc >= rlen) begin
              sel_d   = SEL_MAX;
              state_d = ST_DLOAD;
            end
          end
        end
      end
      // Load one running sum into the divider
      ST_DLOAD: begin
        rem_d  = '0;
        dcnt_d = '0;
        case (sel_q)
          SEL_MAX: quo_d = smax_q;
          SEL_MID: quo_d = smid_q;
          default: quo_d = smin_q;
        endcase
        state_d = ST_DIV;
      end
      // One restoring division step a cycle
      ST_DIV: begin
        rem_d  = dge ? RDG_W'(dshift - {1'b0, rlen}) : dshift[RDG_W-1:0];
        quo_d  = {quo_q[SUM_W-2:0], dge};
        dcnt_d = dcnt_q + DCNT_W'(1);
        if (dcnt_q == DCNT_W'(SUM_W - 1)) begin
          state_d = ST_DSTORE;
        end
      end
      // Store the saturated quotient and move to the next sum
      ST_DSTORE: begin
        case (sel_q)
          SEL_MAX: begin
            amax_d  = quo_sat;
            sel_d   = SEL_MID;
            state_d = ST_DLOAD;
          end
          SEL_MID: begin
            amid_d  = quo_sat;
            sel_d   = SEL_MIN;
            state_d = ST_DLOAD;
          end
          default: begin
            amin_d  = quo_sat;
            state_d = ST_AMP;
          end
        endcase
      end
      // Amplitude, floored at zero
      ST_AMP: begin
        amp_d   = (amid_q > amin_q) ? amid_q - amin_q : '0;
        state_d = ST_EMIT;
      end
      // Debounce, load the output register and clear the sums
      ST_EMIT: begin
        if (out_free) begin
          ouser_d = 1'b0;
          if (in_range) begin
            if (deb_q < DEB_W'(DEBOUNCE_LIMIT)) begin
              deb_d = deb_q + DEB_W'(1);
            end else begin
              ouser_d = 1'b1;
            end
          end else begin
            deb_d = '0;
          end
          odata_d = M_DATA_W'({amp_q, amin_q, amid_q, amax_q});
          ovld_d  = 1'b1;
          smax_d  = '0;
          smid_d  = '0;
          smin_d  = '0;
          wcnt_d  = '0;
          state_d = ST_MUL;
        end
      end
      // Multiply the error by alpha
      ST_MUL: begin
        prod_d  = prod_full[PROD_W-1:0];
        state_d = ST_ADD;
      end
      // Add the floored step, wrapping to the value width
      ST_ADD: begin
        smooth_d = smooth_q + prod_q[ALPHA_SHIFT +: VAL_BITS];
        state_d  = ST_TRK;
      end
      // Update the window extremes
      ST_TRK: begin
        if (smooth_q > wmax_q) begin
          wmax_d = smooth_q;
        end
        if ({1'b0, smooth_q} < wmin_q) begin
          wmin_d = {1'b0, smooth_q};
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RST;
      win_q   <= WIN_RST;
      rdg_q   <= RDG_RST;
      low_q   <= LOW_RST;
      high_q  <= HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ALPHA:  alpha_q <= cfg_data_i[ALPHA_W-1:0];
        CFG_WINDOW: win_q   <= cfg_data_i[WIN_W-1:0];
        CFG_RDG:    rdg_q   <= cfg_data_i[RDG_W-1:0];
        CFG_LOW:    low_q   <= cfg_data_i[THR_W-1:0];
        CFG_HIGH:   high_q  <= cfg_data_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Tracking state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= '0;
      wmax_q   <= '0;
      wmin_q   <= MIN_RST;
      tcnt_q   <= '0;
      smax_q   <= '0;
      smid_q   <= '0;
      smin_q   <= '0;
      wcnt_q   <= '0;
      deb_q    <= '0;
      sel_q    <= SEL_MAX;
      dcnt_q   <= '0;
      ovld_q   <= 1'b0;
    end else begin
      smooth_q <= smooth_d;
      wmax_q   <= wmax_d;
      wmin_q   <= wmin_d;
      tcnt_q   <= tcnt_d;
      smax_q   <= smax_d;
      smid_q   <= smid_d;
      smin_q   <= smin_d;
      wcnt_q   <= wcnt_d;
      deb_q    <= deb_d;
      sel_q    <= sel_d;
      dcnt_q   <= dcnt_d;
      ovld_q   <= ovld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    y_q     <= y_d;
    tick_q  <= tick_d;
    prod_q  <= prod_d;
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    amax_q  <= amax_d;
    amid_q  <= amid_d;
    amin_q  <= amin_d;
    amp_q   <= amp_d;
    odata_q <= odata_d;
    ouser_q <= ouser_d;
  end

endmodule
